/* hw/rtl/isk_pkg.sv */
// ============================================================================
// isk_pkg
// Shared types and constants for the stable key/tag insertion sorter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package isk_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int KEY_W     = 32;
    localparam int TAG_W     = 16;

    // Input item: one key/tag pair, last_in closes the set
    typedef struct packed {
        logic signed [KEY_W-1:0] sort_key;
        logic        [TAG_W-1:0] tag;
        logic                    last_in;
    } in_item_t;

    // Result item: one sorted entry of the set
    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic        [TAG_W-1:0] sorted_tag;
        logic                    last_out;
        logic                    overflow;
    } out_item_t;

    // Contents of one sorting cell
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } entry_t;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic ins;    // insert the broadcast entry
        logic shift;  // move every entry one cell toward the head
    } cell_cmd_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage : isk_pkg

`default_nettype wire

/* hw/rtl/insertion_sort_key_with_tag.sv */
// ============================================================================
// insertion_sort_key_with_tag
// Stable sorter of key/tag items over a chain of MAX_ITEMS insertion cells.
// ============================================================================
// Items of a set enter at one per cycle; each is placed in the chain in the
// cycle it is accepted, after every held key less than or equal to it, so
// equal keys keep arrival order. The item marked last closes the set, and the
// block then stops taking items and delivers the held items in ascending
// key order at up to one per cycle from the head cell. Loading speed is set
// by the signed key compare that every cell makes against the new item in
// parallel. Items beyond MAX_ITEMS are dropped and every result of that set
// carries overflow.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sort_key_with_tag
    import isk_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    cell_cmd_t             cmd;
    entry_t                new_entry;
    entry_t                cell_entry [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  cell_valid;
    logic [MAX_ITEMS-1:0]  cell_gt;
    logic                  dropped;

    assign new_entry.key = s_item.sort_key;
    assign new_entry.tag = s_item.tag;

    // Sequence loading and draining
    isk_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last       (s_item.last_in),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .full         (cell_valid[MAX_ITEMS-1]),
        .second_valid (cell_valid[1]),
        .cmd          (cmd),
        .dropped      (dropped)
    );

    // Build the chain: head cell at index 0, smallest key first
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic   lower_gt;
        entry_t lower_entry;
        logic   lower_valid;
        entry_t upper_entry;
        logic   upper_valid;

        if (i == 0) begin : g_head
            assign lower_gt    = 1'b0;
            assign lower_entry = '0;
            assign lower_valid = 1'b0;
        end else begin : g_body
            assign lower_gt    = cell_gt[i-1];
            assign lower_entry = cell_entry[i-1];
            assign lower_valid = cell_valid[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign upper_entry = '0;
            assign upper_valid = 1'b0;
        end else begin : g_inner
            assign upper_entry = cell_entry[i+1];
            assign upper_valid = cell_valid[i+1];
        end

        isk_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .new_entry   (new_entry),
            .lower_gt    (lower_gt),
            .lower_entry (lower_entry),
            .lower_valid (lower_valid),
            .upper_entry (upper_entry),
            .upper_valid (upper_valid),
            .gt          (cell_gt[i]),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i])
        );
    end

    // Present the head cell as the result item
    assign m_item.sorted_key = cell_entry[0].key;
    assign m_item.sorted_tag = cell_entry[0].tag;
    assign m_item.last_out   = !cell_valid[1];
    assign m_item.overflow   = dropped;

    // A result is offered only from a filled head cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cell_valid[0])
        else $error("result offered from empty head cell");

    // Loading and draining never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input and output open at once");

    // A filled second cell implies a filled head cell with a key no greater
    assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[1] |-> (cell_valid[0] && (cell_entry[0].key <= cell_entry[1].key)))
        else $error("chain head out of order");

    // Taking the final result leaves the chain empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_item.last_out) |=> (cell_valid == '0))
        else $error("chain not empty after final result");

endmodule : insertion_sort_key_with_tag

`default_nettype wire

/* hw/rtl/isk_cell.sv */
// ============================================================================
// isk_cell
// One cell of the insertion chain: holds one entry and its valid bit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module isk_cell
    import isk_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_cmd_t cmd,
    input  wire entry_t    new_entry,
    input  wire logic      lower_gt,
    input  wire entry_t    lower_entry,
    input  wire logic      lower_valid,
    input  wire entry_t    upper_entry,
    input  wire logic      upper_valid,
    output logic           gt,
    output entry_t         entry,
    output logic           valid
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // An empty cell counts as greater, so a new entry no smaller than every held key lands at the first free cell
    assign gt = !valid_reg || (entry_reg.key > new_entry.key);

    // Choose: take lower neighbor, take new entry, take upper neighbor, or hold
    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.shift) begin
            entry_next = upper_entry;
            valid_next = upper_valid;
        end else if (cmd.ins && gt) begin
            if (lower_gt) begin
                entry_next = lower_entry;
                valid_next = lower_valid;
            end else begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
        end
    end

    // Hold payload without reset, clear valid on reset
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule : isk_cell

`default_nettype wire

/* hw/rtl/isk_ctrl.sv */
// ============================================================================
// isk_ctrl
// Load/drain sequencer and overflow flag for the insertion chain.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module isk_ctrl
    import isk_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire logic  s_last,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire logic  full,
    input  wire logic  second_valid,
    output cell_cmd_t  cmd,
    output logic       dropped
);

    state_t state_reg;
    state_t state_next;
    logic   dropped_reg;
    logic   dropped_next;

    // Register state and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    // Next state, cell commands and handshakes
    always_comb begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // Drop the item when every cell is taken
                    cmd.ins = !full;
                    if (full) begin
                        dropped_next = 1'b1;
                    end
                    if (s_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.shift = 1'b1;
                    if (!second_valid) begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign dropped = dropped_reg;

endmodule : isk_ctrl

`default_nettype wire
